@@ src/deq_pkg.sv @@
package deq_pkg;

  // Opcodes of an input beat
  localparam logic [2:0] OP_PUSH_L = 3'd0;
  localparam logic [2:0] OP_PUSH_R = 3'd1;
  localparam logic [2:0] OP_POP_L  = 3'd2;
  localparam logic [2:0] OP_POP_R  = 3'd3;
  localparam logic [2:0] OP_PEEK_L = 3'd4;
  localparam logic [2:0] OP_PEEK_R = 3'd5;
  localparam logic [2:0] OP_REV    = 3'd6;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_NULL  = 2'd3;

  // Ring access requested by the controller for one beat
  typedef struct packed {
    logic       wr;      // write the ring entry
    logic       rd;      // read the ring entry, result carries the word
    logic [1:0] status;
  } deq_req_t;

endpackage

@@ src/deq_ctrl.sv @@
module deq_ctrl #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned SW    = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [2:0]        opcode_i,
  input  logic [SW-1:0]     word_i,
  output deq_pkg::deq_req_t req_o,
  output logic [AW-1:0]     addr_o,
  output logic [CntW-1:0]   count_o
);
  import deq_pkg::*;

  localparam logic [AW:0]     DepthW = (AW+1)'(DEPTH);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);
  localparam logic [AW-1:0]   LastIx = AW'(DEPTH - 1);

  logic [AW-1:0]   head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic            rev_q, rev_d;

  logic            empty, full, null_word;
  logic            left_op, at_front;
  logic [AW:0]     tail_sum, back_sum;
  logic [AW-1:0]   tail_pos, back_pos, head_dec, head_inc;
  deq_req_t        req;

  // Ring positions: slot after the back end, last entry, neighbours of head
  always_comb begin
    tail_sum = (AW+1)'(head_q) + (AW+1)'(count_q);
    back_sum = (AW+1)'(head_q) + (AW+1)'(count_q - CntW'(1));
    tail_pos = (tail_sum >= DepthW) ? AW'(tail_sum - DepthW) : AW'(tail_sum);
    back_pos = (back_sum >= DepthW) ? AW'(back_sum - DepthW) : AW'(back_sum);
    head_dec = (head_q == '0) ? LastIx : head_q - AW'(1);
    head_inc = (head_q == LastIx) ? '0 : head_q + AW'(1);
  end

  assign empty     = (count_q == '0);
  assign full      = (count_q == DepthC);
  assign null_word = (word_i == '0);
  // Even opcodes of pushes, pops and peeks act on the left end
  assign left_op   = ~opcode_i[0];
  assign at_front  = left_op ^ rev_q;

  // Decode the beat against the current ring state
  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    rev_d      = rev_q;
    req        = '0;
    req.status = ST_OK;
    addr_o     = head_q;
    unique case (opcode_i)
      OP_PUSH_L, OP_PUSH_R: begin
        if (null_word) begin
          req.status = ST_NULL;
        end else if (full) begin
          req.status = ST_FULL;
        end else begin
          req.wr  = 1'b1;
          count_d = count_q + CntW'(1);
          if (at_front) begin
            head_d = head_dec;
            addr_o = head_dec;
          end else begin
            addr_o = tail_pos;
          end
        end
      end
      OP_POP_L, OP_POP_R, OP_PEEK_L, OP_PEEK_R: begin
        if (empty) begin
          req.status = ST_EMPTY;
        end else begin
          req.rd = 1'b1;
          addr_o = at_front ? head_q : back_pos;
          if (opcode_i == OP_POP_L || opcode_i == OP_POP_R) begin
            count_d = count_q - CntW'(1);
            if (at_front) head_d = head_inc;
          end
        end
      end
      OP_REV: begin
        rev_d = ~rev_q;
      end
      default: begin
        // unused opcode: no effect
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      rev_q   <= 1'b0;
    end else if (accept_i) begin
      head_q  <= head_d;
      count_q <= count_d;
      rev_q   <= rev_d;
    end
  end

  always_comb begin
    req_o        = req;
    req_o.wr     = req.wr & accept_i;
    req_o.rd     = req.rd & accept_i;
  end
  assign count_o = count_d;

endmodule

@@ src/double_ended_queue_top.sv @@
// Channel | valid      | ready      | payload
// in      | in_valid_i | in_ready_o | opcode_i, data_in_i
// out     | out_valid_o| out_ready_i| data_out_o, data_valid_o, status_o, entry_count_out_o
//
// One beat per cycle unless stalled; results pass the pending stage and output register.
// Head, count and orientation update at accept; the ring RAM is written or read
// at that edge and the read word lands in the pending stage the cycle after.
// Reset clears the pointers, count, orientation and both stage valids; ring
// contents are undefined and never read before being written.
// A stalled output holds the pending stage, which holds the input side.
module double_ended_queue_top #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned CntW      = $clog2(DEPTH + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2:0]      opcode_i,
  input  logic [31:0]     data_in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [31:0]     data_out_o,
  output logic            data_valid_o,
  output logic [1:0]      status_o,
  output logic [CntW-1:0] entry_count_out_o
);
  import deq_pkg::*;

  localparam int unsigned SW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic            accept;
  deq_req_t        req;
  logic [AW-1:0]   addr;
  logic [CntW-1:0] count;

  logic [SW-1:0]   ring_mem [DEPTH];
  logic [SW-1:0]   rdata_q;

  logic            p_valid_q, p_rd_q;
  logic [1:0]      p_status_q;
  logic [CntW-1:0] p_count_q;
  logic            p_move, out_free;

  logic            o_valid_q, o_dvalid_q;
  logic [31:0]     o_data_q;
  logic [1:0]      o_status_q;
  logic [CntW-1:0] o_count_q;

  assign out_free   = ~o_valid_q | out_ready_i;
  assign p_move     = p_valid_q & out_free;
  assign in_ready_o = ~p_valid_q | out_free;
  assign accept     = in_valid_i & in_ready_o;

  deq_ctrl #(
    .DEPTH (DEPTH),
    .SW    (SW)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .opcode_i (opcode_i),
    .word_i   (data_in_i[SW-1:0]),
    .req_o    (req),
    .addr_o   (addr),
    .count_o  (count)
  );

  // Ring RAM, one access per beat, registered read
  always_ff @(posedge clk_i) begin
    if (req.wr) ring_mem[addr] <= data_in_i[SW-1:0];
    if (req.rd) rdata_q <= ring_mem[addr];
  end

  // Pending stage: waits for the RAM word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (accept) begin
      p_valid_q <= 1'b1;
    end else if (p_move) begin
      p_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_rd_q     <= req.rd;
      p_status_q <= req.status;
      p_count_q  <= count;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (p_move) begin
      o_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_move) begin
      o_data_q   <= p_rd_q ? 32'(rdata_q) : '0;
      o_dvalid_q <= p_rd_q;
      o_status_q <= p_status_q;
      o_count_q  <= p_count_q;
    end
  end

  assign out_valid_o       = o_valid_q;
  assign data_out_o        = o_data_q;
  assign data_valid_o      = o_dvalid_q;
  assign status_o          = o_status_q;
  assign entry_count_out_o = o_count_q;

`ifndef ASSERT_OFF
  a_dvalid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q && o_dvalid_q |-> o_status_q == ST_OK)
    else $error("data valid with non-ok status");
  a_pend_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q && !out_free |=> p_valid_q)
    else $error("pending beat lost under stall");
  a_accept_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> p_valid_q)
    else $error("accepted beat not pending");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> count <= CntW'(DEPTH))
    else $error("entry count beyond depth");
`endif

endmodule
